[rtl/slvw_pkg.sv]
package slvw_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef enum logic [1:0] {
    KIND_WORD      = 2'd0,
    KIND_FILL      = 2'd1,
    KIND_HIGH_BYTE = 2'd2,
    KIND_END       = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_list;
  } in_t;

  typedef struct packed {
    kind_e        write_kind;
    logic [14:0]  word_address;
    logic         address_step;
    logic [13:0]  repeat_count;
    logic [15:0]  write_data;
    logic         is_last;
  } res_t;

  // results of one parsed byte going into the command queue
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

[rtl/slvw_in_if.sv]
interface slvw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_list;

  modport source (output valid, output data_byte, output start_of_list, input ready);
  modport sink (input valid, input data_byte, input start_of_list, output ready);
endinterface

[rtl/slvw_out_if.sv]
interface slvw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  write_kind;
  logic [14:0] word_address;
  logic        address_step;
  logic [13:0] repeat_count;
  logic [15:0] write_data;
  logic        is_last;

  modport source (
    output valid, output write_kind, output word_address, output address_step,
    output repeat_count, output write_data, output is_last, input ready
  );
  modport sink (
    input valid, input write_kind, input word_address, input address_step,
    input repeat_count, input write_data, input is_last, output ready
  );
endinterface

[rtl/slvw_parser.sv]
module slvw_parser import slvw_pkg::*; #(
  parameter int unsigned ADDR_BITS   = 15,
  parameter int unsigned LENGTH_BITS = 14
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_word_i,
  input  logic  room_i,
  output push_t push_o,
  output res_t  res0_o,
  output res_t  res1_o
);

  localparam int unsigned REM_W = LENGTH_BITS + 1;
  localparam int unsigned IDX_W = LENGTH_BITS - 1;
  localparam int unsigned OFF_W = IDX_W + 5;

  typedef enum logic [6:0] {
    PH_HDR0  = 7'b0000001,
    PH_HDR1  = 7'b0000010,
    PH_HDR2  = 7'b0000100,
    PH_HDR3  = 7'b0001000,
    PH_LOW   = 7'b0010000,
    PH_HIGH  = 7'b0100000,
    PH_ENDED = 7'b1000000
  } phase_e;

  logic                 in_vld_q;
  in_t                  in_q;
  logic                 fire;

  phase_e               phase_q, phase_d, ph_eff;
  logic [ADDR_BITS-1:0] base_q, base_d;
  logic                 step_q, step_d;
  logic                 fill_q, fill_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [7:0]           held_q, held_d;
  logic [5:0]           lenhi_q, lenhi_d;

  logic [7:0]           b;
  logic [13:0]          raw_len;
  logic [REM_W-1:0]     rem_dec;
  logic [REM_W:0]       fill_words;
  logic [OFF_W-1:0]     offset;
  logic [ADDR_BITS-1:0] copy_addr;
  logic [ADDR_BITS-1:0] tail_addr;

  assign fire       = in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_word_i;
    end
  end

  assign b          = in_q.data_byte;
  assign ph_eff     = in_q.start_of_list ? PH_HDR0 : phase_q;
  assign raw_len    = {lenhi_q, b};
  assign rem_dec    = rem_q - REM_W'(1);
  assign fill_words = ((REM_W + 1)'(rem_q) + (REM_W + 1)'(1)) >> 1;
  assign offset     = step_q ? {idx_q, 5'b00000} : OFF_W'(idx_q);
  assign copy_addr  = base_q + ADDR_BITS'(offset);
  assign tail_addr  = base_q + ADDR_BITS'(rem_q >> 1);

  always_comb begin
    phase_d = phase_q;
    base_d  = base_q;
    step_d  = step_q;
    fill_d  = fill_q;
    rem_d   = rem_q;
    idx_d   = idx_q;
    held_d  = held_q;
    lenhi_d = lenhi_q;
    push_o  = '0;
    res0_o  = '0;
    res1_o  = '0;
    res0_o.write_kind = KIND_WORD;
    res1_o.write_kind = KIND_WORD;

    unique case (ph_eff)
      PH_HDR0: begin
        if (b[7]) begin
          push_o.first      = 1'b1;
          res0_o.write_kind = KIND_END;
          phase_d           = PH_ENDED;
        end else begin
          base_d  = ADDR_BITS'({b, 8'h00});
          phase_d = PH_HDR1;
        end
      end
      PH_HDR1: begin
        base_d  = base_q | ADDR_BITS'(b);
        phase_d = PH_HDR2;
      end
      PH_HDR2: begin
        step_d  = b[7];
        fill_d  = b[6];
        lenhi_d = b[5:0];
        phase_d = PH_HDR3;
      end
      PH_HDR3: begin
        rem_d   = REM_W'(raw_len[LENGTH_BITS-1:0]) + REM_W'(1);
        idx_d   = '0;
        phase_d = PH_LOW;
      end
      PH_LOW: begin
        held_d = b;
        if (fill_q) begin
          phase_d = PH_HIGH;
        end else begin
          rem_d   = rem_dec;
          phase_d = (rem_dec == '0) ? PH_HDR0 : PH_HIGH;
        end
      end
      PH_HIGH: begin
        push_o.first       = 1'b1;
        res0_o.write_data  = {b, held_q};
        if (fill_q) begin
          res0_o.write_kind   = KIND_FILL;
          res0_o.word_address = 15'(base_q);
          res0_o.address_step = step_q;
          res0_o.repeat_count = 14'(fill_words);
          // even length with unit stride also patches the high half past the fill
          if (!step_q && !rem_q[0]) begin
            push_o.second       = 1'b1;
            res1_o.write_kind   = KIND_HIGH_BYTE;
            res1_o.word_address = 15'(tail_addr);
            res1_o.write_data   = {held_q, 8'h00};
          end
          phase_d = PH_HDR0;
        end else begin
          res0_o.write_kind   = KIND_WORD;
          res0_o.word_address = 15'(copy_addr);
          idx_d               = idx_q + IDX_W'(1);
          rem_d               = rem_dec;
          phase_d             = (rem_dec == '0) ? PH_HDR0 : PH_LOW;
        end
      end
      PH_ENDED: begin
        phase_d = PH_ENDED;
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    res0_o.is_last = !push_o.second;
    res1_o.is_last = 1'b1;
    if (!fire) begin
      push_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      base_q  <= '0;
      step_q  <= 1'b0;
      fill_q  <= 1'b0;
      rem_q   <= '0;
      idx_q   <= '0;
      held_q  <= '0;
      lenhi_q <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      base_q  <= base_d;
      step_q  <= step_d;
      fill_q  <= fill_d;
      rem_q   <= rem_d;
      idx_q   <= idx_d;
      held_q  <= held_d;
      lenhi_q <= lenhi_d;
    end
  end

`ifndef ASSERT_OFF
  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.second |-> push_o.first)
    else $error("second command without first");

  a_push_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.first |-> fire)
    else $error("command pushed without a parsed byte");

  a_hdr3_to_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ph_eff == PH_HDR3) |=> phase_q == PH_LOW)
    else $error("last header byte did not start the record body");
`endif

endmodule

[rtl/slvw_cmd_fifo.sv]
module slvw_cmd_fifo import slvw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  res_t  res0_i,
  input  res_t  res1_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_word_o
);

  res_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_next;
  logic [FIFO_CNT_W-1:0] count_q;
  logic [FIFO_CNT_W-1:0] push_n;
  logic                  pop;

  assign wr_next     = wr_ptr_q + FIFO_PTR_W'(1);
  assign push_n      = FIFO_CNT_W'(push_i.first) + FIFO_CNT_W'(push_i.second);
  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  // room for the worst case of two commands from one byte
  assign room_o      = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign out_word_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_i.second) begin
      mem_q[wr_next] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      count_q <= count_q + push_n - FIFO_CNT_W'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("command queue overflow");

  a_push_with_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.first |-> room_o)
    else $error("push into a full command queue");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_i.first && pop) |=> count_q == $past(count_q) - FIFO_CNT_W'(1))
    else $error("queue count lost a pop");
`endif

endmodule

[rtl/stripe_list_vram_writer_unit.sv]
// Stripe list video-memory writer: takes one byte of an upload record list per word on
// bytes_i and issues word writes, fill commands, high-byte writes and a list-ended marker
// on cmds_o. Bytes are taken back to back while the queue has room; a byte is parsed from an
// input register and its commands (at most two, the second only for the last byte of a fill
// record) enter a four-entry command queue, from which cmds_o is offered once the byte has
// passed the input register and been written into the queue. A byte is parsed only while the
// queue has two free entries, so the sustained rate is one byte per cycle while the sink
// takes one command per cycle. is_last marks the final command caused by a byte;
// start_of_list restarts parsing at a header.
module stripe_list_vram_writer_unit import slvw_pkg::*; #(
  parameter int unsigned ADDR_BITS   = 15,
  parameter int unsigned LENGTH_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  slvw_in_if.sink   bytes_i,
  slvw_out_if.source cmds_o
);

  in_t   in_word;
  push_t push;
  res_t  res0, res1, out_word;
  logic  room;

  assign in_word.data_byte     = bytes_i.data_byte;
  assign in_word.start_of_list = bytes_i.start_of_list;

  slvw_parser #(
    .ADDR_BITS   (ADDR_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (bytes_i.valid),
    .in_ready_o (bytes_i.ready),
    .in_word_i  (in_word),
    .room_i     (room),
    .push_o     (push),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  slvw_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res0_i      (res0),
    .res1_i      (res1),
    .room_o      (room),
    .out_valid_o (cmds_o.valid),
    .out_ready_i (cmds_o.ready),
    .out_word_o  (out_word)
  );

  assign cmds_o.write_kind   = out_word.write_kind;
  assign cmds_o.word_address = out_word.word_address;
  assign cmds_o.address_step = out_word.address_step;
  assign cmds_o.repeat_count = out_word.repeat_count;
  assign cmds_o.write_data   = out_word.write_data;
  assign cmds_o.is_last      = out_word.is_last;

endmodule

[tb/sv/stripe_list_vram_writer_unit_tb.sv]
`timescale 1ns / 1ps

module stripe_list_vram_writer_unit_tb;
  import slvw_pkg::*;

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned ITEM_TARGET = 1300;

  typedef enum logic [2:0] {
    P_HDR0  = 3'd0,
    P_HDR1  = 3'd1,
    P_HDR2  = 3'd2,
    P_HDR3  = 3'd3,
    P_LOW   = 3'd4,
    P_HIGH  = 3'd5,
    P_ENDED = 3'd6
  } phase_e;

  typedef struct {
    logic [7:0] b;
    logic       sol;
    bit         sync;  // hold the sender until every command is back
  } byte_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  slvw_in_if in_bus ();
  slvw_out_if cmd_bus ();

  stripe_list_vram_writer_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .bytes_i (in_bus),
    .cmds_o  (cmd_bus)
  );

  byte_item_t pending_bytes[$];
  res_t expected_cmds[$];
  int unsigned total_bytes = 0;
  int unsigned accepted_bytes = 0;
  int unsigned gen_items = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  bit tail_wait = 1'b0;

  // parser state mirrored from the block
  phase_e      ph = P_HDR0;
  logic [14:0] base_addr = '0;
  logic        row_step = 1'b0;
  logic        fill_on = 1'b0;
  logic [14:0] remaining = '0;
  logic [12:0] widx = '0;
  logic [7:0]  held = '0;
  logic [5:0]  len_hi = '0;

  function automatic res_t make_cmd(input kind_e k, input logic [14:0] a, input logic s,
                                    input logic [13:0] rc, input logic [15:0] d);
    res_t c;
    c.write_kind = k;
    c.word_address = a;
    c.address_step = s;
    c.repeat_count = rc;
    c.write_data = d;
    c.is_last = 1'b0;
    return c;
  endfunction

  function automatic void predict_cmds(input logic [7:0] b, input logic sol);
    res_t cmd_a;
    res_t cmd_b;
    int n;
    logic [14:0] half_up;
    logic [14:0] offs;
    n = 0;
    if (sol) ph = P_HDR0;
    case (ph)
      P_HDR0: begin
        if (b[7]) begin
          cmd_a = make_cmd(KIND_END, '0, 1'b0, '0, '0);
          n = 1;
          ph = P_ENDED;
        end else begin
          base_addr = {b[6:0], 8'h00};
          ph = P_HDR1;
        end
      end
      P_HDR1: begin
        base_addr = base_addr | {7'h00, b};
        ph = P_HDR2;
      end
      P_HDR2: begin
        row_step = b[7];
        fill_on = b[6];
        len_hi = b[5:0];
        ph = P_HDR3;
      end
      P_HDR3: begin
        remaining = {1'b0, len_hi, b} + 15'd1;
        widx = '0;
        ph = P_LOW;
      end
      P_LOW: begin
        held = b;
        if (fill_on) begin
          ph = P_HIGH;
        end else begin
          remaining = remaining - 15'd1;
          ph = (remaining == '0) ? P_HDR0 : P_HIGH;
        end
      end
      P_HIGH: begin
        if (fill_on) begin
          half_up = (remaining + 15'd1) >> 1;
          cmd_a = make_cmd(KIND_FILL, base_addr, row_step, half_up[13:0], {b, held});
          n = 1;
          // even fill length at stride 1 tops up the word past the fill
          if (!row_step && !remaining[0]) begin
            cmd_b = make_cmd(KIND_HIGH_BYTE, base_addr + (remaining >> 1), 1'b0, '0,
                             {held, 8'h00});
            n = 2;
          end
          ph = P_HDR0;
        end else begin
          offs = row_step ? {widx[9:0], 5'b00000} : {2'b00, widx};
          cmd_a = make_cmd(KIND_WORD, base_addr + offs, 1'b0, '0, {b, held});
          n = 1;
          widx = widx + 13'd1;
          remaining = remaining - 15'd1;
          ph = (remaining == '0) ? P_HDR0 : P_LOW;
        end
      end
      default: begin
      end
    endcase
    if (n == 1) begin
      cmd_a.is_last = 1'b1;
      expected_cmds.push_back(cmd_a);
    end else if (n == 2) begin
      cmd_b.is_last = 1'b1;
      expected_cmds.push_back(cmd_a);
      expected_cmds.push_back(cmd_b);
    end
  endfunction

  function automatic void check_cmd();
    res_t got;
    res_t want;
    got.write_kind = kind_e'(cmd_bus.write_kind);
    got.word_address = cmd_bus.word_address;
    got.address_step = cmd_bus.address_step;
    got.repeat_count = cmd_bus.repeat_count;
    got.write_data = cmd_bus.write_data;
    got.is_last = cmd_bus.is_last;
    if (expected_cmds.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected command: kind %0d addr %h step %0d count %0d data %h last %0d",
                 got.write_kind, got.word_address, got.address_step, got.repeat_count,
                 got.write_data, got.is_last);
    end else begin
      want = expected_cmds.pop_front();
      if (got.write_kind !== want.write_kind || got.word_address !== want.word_address ||
          got.address_step !== want.address_step || got.repeat_count !== want.repeat_count ||
          got.write_data !== want.write_data || got.is_last !== want.is_last) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("wrong command: kind %0d addr %h step %0d count %0d data %h last %0d",
                   got.write_kind, got.word_address, got.address_step, got.repeat_count,
                   got.write_data, got.is_last);
          $display("  wanted:      kind %0d addr %h step %0d count %0d data %h last %0d",
                   want.write_kind, want.word_address, want.address_step, want.repeat_count,
                   want.write_data, want.is_last);
        end
      end
    end
  endfunction

  function automatic int unsigned pick_idle(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic sol, input bit counted);
    byte_item_t it;
    it.b = b;
    it.sol = sol;
    it.sync = 1'b0;
    pending_bytes.push_back(it);
    total_bytes++;
    if (counted) gen_items++;
  endtask

  task automatic put_drain();
    byte_item_t it;
    it.b = '0;
    it.sol = 1'b0;
    it.sync = 1'b1;
    pending_bytes.push_back(it);
  endtask

  task automatic put_header(input logic [14:0] addr, input logic row, input logic fill,
                            input logic [13:0] len, input logic sol);
    put_byte({1'b0, addr[14:8]}, sol, 1'b1);
    put_byte(addr[7:0], 1'b0, 1'b1);
    put_byte({row, fill, len[13:8]}, 1'b0, 1'b1);
    put_byte(len[7:0], 1'b0, 1'b1);
  endtask

  task automatic put_copy(input logic [14:0] addr, input logic row, input logic [13:0] len,
                          input logic sol);
    put_header(addr, row, 1'b0, len, sol);
    for (int i = 0; i <= int'(len); i++) put_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic put_fill(input logic [14:0] addr, input logic row, input logic [13:0] len,
                          input logic [15:0] w, input logic sol);
    put_header(addr, row, 1'b1, len, sol);
    put_byte(w[7:0], 1'b0, 1'b1);
    put_byte(w[15:8], 1'b0, 1'b1);
  endtask

  task automatic put_end(input logic sol);
    put_byte({1'b1, 7'($urandom)}, sol, 1'b1);
  endtask

  task automatic put_junk(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) put_byte(8'($urandom), 1'b0, 1'b0);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.data_byte <= '0;
      in_bus.start_of_list <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_cmds(in_bus.data_byte, in_bus.start_of_list);
        accepted_bytes++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_bytes.size() != 0 && pending_bytes[0].sync) begin
          in_bus.valid <= 1'b0;
          if (expected_cmds.size() == 0) void'(pending_bytes.pop_front());
        end else if (pending_bytes.size() != 0) begin
          in_bus.valid <= 1'b1;
          in_bus.data_byte <= pending_bytes[0].b;
          in_bus.start_of_list <= pending_bytes[0].sol;
          void'(pending_bytes.pop_front());
          send_gap <= pick_idle(send_calm);
          if ($urandom_range(0, 99) == 0) send_calm <= ~send_calm;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_bus.ready <= 1'b0;
      recv_stall <= 0;
      idle_cycles <= 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) check_cmd();
      if ((cmd_bus.valid && cmd_bus.ready) || (in_bus.valid && in_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (tail_wait) begin
        cmd_bus.ready <= 1'b1;
      end else if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        cmd_bus.ready <= 1'b0;
      end else begin
        cmd_bus.ready <= 1'b1;
        recv_stall <= pick_idle(recv_calm);
        if ($urandom_range(0, 99) == 0) recv_calm <= ~recv_calm;
      end
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("stripe_list_vram_writer_unit: mismatch");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned nrec;
    logic [14:0] addr;
    logic [13:0] len;
    logic sol;
    bit need_start;

    // no start flag: parsing is at a header right after reset
    put_fill(15'h7FFF, 1'b0, 14'h3FFF, 16'hFFFF, 1'b0);
    put_fill(15'h1234, 1'b1, 14'h0001, 16'h00FF, 1'b0);
    // stride 32 copy that wraps, odd byte count so the last byte is dropped
    put_copy(15'h7FF0, 1'b1, 14'd4, 1'b0);
    // restart in the middle of a header straight into a list end
    put_byte(8'h12, 1'b0, 1'b1);
    put_byte(8'h34, 1'b0, 1'b1);
    put_end(1'b1);
    put_junk(2);
    put_drain();

    need_start = 1'b1;
    while (gen_items < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        nrec = $urandom_range(1, 4);
        for (int unsigned k = 0; k < nrec; k++) begin
          sol = (k == 0) && (need_start || $urandom_range(0, 1) == 1);
          addr = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(15'h7FC0, 15'h7FFF))
                                             : 15'($urandom);
          if ($urandom_range(0, 1) == 0) begin
            r = $urandom_range(0, 99);
            if (r < 70) len = 14'($urandom_range(0, 15));
            else if (r < 95) len = 14'($urandom_range(16, 63));
            else len = 14'($urandom_range(64, 300));
            put_copy(addr, 1'($urandom), len, sol);
          end else begin
            r = $urandom_range(0, 99);
            if (r < 50) len = 14'($urandom_range(0, 31));
            else if (r < 90) len = 14'($urandom);
            else len = ($urandom_range(0, 1) == 1) ? 14'h3FFF - 14'($urandom_range(0, 1))
                                                   : 14'($urandom_range(0, 1));
            put_fill(addr, 1'($urandom), len, 16'($urandom), sol);
          end
        end
        if ($urandom_range(0, 99) < 85) begin
          put_end(1'b0);
          put_junk($urandom_range(0, 3));
          need_start = 1'b1;
        end else begin
          need_start = 1'b0;
        end
      end else if (r < 95) begin
        // record cut short by the next list start
        put_header(15'($urandom), 1'($urandom), 1'($urandom), 14'($urandom_range(0, 40)),
                   1'b1);
        nrec = $urandom_range(0, 3);
        for (int unsigned k = 0; k < nrec; k++) put_byte(8'($urandom), 1'b0, 1'b1);
        need_start = 1'b1;
      end else begin
        nrec = $urandom_range(1, 6);
        for (int unsigned k = 0; k < nrec; k++)
          put_byte(8'($urandom), ($urandom_range(0, 3) == 0), 1'b1);
        need_start = 1'b1;
      end
      if ($urandom_range(0, 39) == 0) put_drain();
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_bytes == total_bytes && expected_cmds.size() == 0);
    tail_wait = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_cmds.size() == 0) begin
      $display("stripe_list_vram_writer_unit: match");
    end else begin
      $display("stripe_list_vram_writer_unit: mismatch");
    end
    $finish;
  end

endmodule
